FILE: rtl/rtef_pkg.sv
// Shared constants, payload types and scan unit interface types of the row track edge finder.
`default_nettype none

package rtef_pkg;

    localparam int ROW_PIXELS = 320;
    localparam int ROW_BYTES  = 40;
    localparam int PIX_WORDS  = (ROW_PIXELS + 7) / 8;
    localparam int ADDR_W     = $clog2(PIX_WORDS);
    localparam int CNT_W      = $clog2(ROW_BYTES + 1);
    localparam int COL_W      = (($clog2(ROW_PIXELS) > 9) ? $clog2(ROW_PIXELS) : 9) + 2;

    localparam logic [2:0] CFG_SCAN_START  = 3'd0;
    localparam logic [2:0] CFG_LEFT_LIMIT  = 3'd1;
    localparam logic [2:0] CFG_RIGHT_LIMIT = 3'd2;
    localparam logic [2:0] CFG_SINGLE_HW   = 3'd3;
    localparam logic [2:0] CFG_WIDTH_LOW   = 3'd4;
    localparam logic [2:0] CFG_WIDTH_HIGH  = 3'd5;
    localparam logic [2:0] CFG_CENTRE_LOW  = 3'd6;
    localparam logic [2:0] CFG_CENTRE_HIGH = 3'd7;

    localparam logic [8:0] RST_SCAN_START  = 9'd160;
    localparam logic [8:0] RST_LEFT_LIMIT  = 9'd5;
    localparam logic [8:0] RST_RIGHT_LIMIT = 9'd315;
    localparam logic [7:0] RST_SINGLE_HW   = 8'd50;
    localparam logic [7:0] RST_WIDTH_LOW   = 8'd80;
    localparam logic [7:0] RST_WIDTH_HIGH  = 8'd110;
    localparam logic [8:0] RST_CENTRE_LOW  = 9'd60;
    localparam logic [8:0] RST_CENTRE_HIGH = 9'd250;

    typedef logic signed [COL_W-1:0] t_col;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic [7:0] row_index;
        logic       row_end;
    } t_in;

    typedef struct packed {
        logic [7:0] row_tag;
        logic [8:0] centre_col;
        logic [8:0] left_edge;
        logic [8:0] right_edge;
        logic [7:0] half_width;
        logic       left_found;
        logic       right_found;
    } t_out;

    typedef struct packed {
        logic       go;
        logic       dir_left;
        logic [8:0] start;
        logic [8:0] limit;
    } t_scan_req;

    typedef struct packed {
        logic done;
        logic found;
        t_col edge_col;
    } t_scan_rsp;

endpackage

`default_nettype wire

FILE: rtl/rtef_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module rtef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/rtef_scan.sv
// Pixel walker that scans the stored row one column a cycle for three black pixels.
`default_nettype none

module rtef_scan (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire rtef_pkg::t_scan_req       i_req,
    output rtef_pkg::t_scan_rsp            o_rsp,
    output logic [rtef_pkg::ADDR_W-1:0]    o_raddr,
    input  wire logic [7:0]                i_rdata
);

    typedef enum logic {W_IDLE, W_RUN} t_wstate;

    t_wstate        r_state;
    logic           r_dir;
    rtef_pkg::t_col r_limit;
    rtef_pkg::t_col r_pos;
    rtef_pkg::t_col r_issue;
    logic           r_pend_valid;
    logic           r_pend_ok;
    logic [2:0]     r_pend_bit;
    logic [2:0]     r_win;
    logic [1:0]     r_fill;

    logic           issue_ok;
    logic           pixel;
    logic           at_limit;
    logic           stop;
    rtef_pkg::t_col step;
    rtef_pkg::t_col start_col;

    always_comb begin
        issue_ok  = (r_issue >= rtef_pkg::t_col'(0))
                 && (r_issue < rtef_pkg::t_col'(rtef_pkg::ROW_PIXELS));
        o_raddr   = issue_ok ? r_issue[3 +: rtef_pkg::ADDR_W] : '0;
        pixel     = r_pend_ok & i_rdata[3'd7 - r_pend_bit];
        at_limit  = r_dir ? (r_pos <= r_limit) : (r_pos >= r_limit);
        stop      = (r_state == W_RUN) && (r_fill == 2'd3) && ((&r_win) || at_limit);
        step      = r_dir ? rtef_pkg::t_col'(-1) : rtef_pkg::t_col'(1);
        start_col = rtef_pkg::t_col'(i_req.start);
        o_rsp.done     = stop;
        o_rsp.found    = !at_limit;
        o_rsp.edge_col = r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= W_IDLE;
            r_pend_valid <= 1'b0;
            r_fill       <= 2'd0;
        end else if (i_req.go) begin
            r_state      <= W_RUN;
            r_dir        <= i_req.dir_left;
            r_limit      <= rtef_pkg::t_col'(i_req.limit);
            r_pos        <= start_col;
            r_issue      <= i_req.dir_left ? start_col - rtef_pkg::t_col'(1)
                                           : start_col + rtef_pkg::t_col'(1);
            r_pend_valid <= 1'b0;
            r_fill       <= 2'd0;
        end else if (r_state == W_RUN) begin
            if (stop) begin
                r_state      <= W_IDLE;
                r_pend_valid <= 1'b0;
            end else begin
                r_issue      <= r_issue + step;
                r_pend_valid <= 1'b1;
                r_pend_ok    <= issue_ok;
                r_pend_bit   <= r_issue[2:0];
                if (r_pend_valid) begin
                    r_win <= {r_win[1:0], pixel};
                    if (r_fill != 2'd3) begin
                        r_fill <= r_fill + 2'd1;
                    end else begin
                        r_pos <= r_pos + step;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/row_track_edge_finder_unit.sv
// Top level of the row track edge finder: byte store, scan sequencer and result stage.
// A byte that does not end a row is taken and gives no result.
// On the last byte the shared walker scans right, then left; the result is then worked
// out and clamped, and loaded into the output register once it is free.
// Throughput: one byte a cycle while a row loads; input waits until its result is loaded.
// Reset (synchronous, active low) restores register defaults, clears the byte count
// and the kept edges; the pixel store itself is not cleared.
`default_nettype none

module row_track_edge_finder_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire rtef_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output rtef_pkg::t_out      o_out_data,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [2:0]     i_cfg_index,
    input  wire logic [8:0]     i_cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_RIGHT, S_LEFT, S_CALC, S_CLAMP} t_state;

    t_state                       r_state;
    logic [rtef_pkg::CNT_W-1:0]   r_count;
    logic [8:0]                   r_scan_start;
    logic [8:0]                   r_left_limit;
    logic [8:0]                   r_right_limit;
    logic [7:0]                   r_single_hw;
    logic [7:0]                   r_width_low;
    logic [7:0]                   r_width_high;
    logic [8:0]                   r_centre_low;
    logic [8:0]                   r_centre_high;
    logic [8:0]                   r_prev_left;
    logic [8:0]                   r_prev_right;
    logic                         r_go;
    logic                         r_dir_left;
    logic [7:0]                   r_tag;
    logic                         r_rf;
    logic                         r_lf;
    rtef_pkg::t_col               r_r;
    rtef_pkg::t_col               r_l;
    rtef_pkg::t_col               r_centre;
    rtef_pkg::t_col               r_hw;
    rtef_pkg::t_col               r_le;
    rtef_pkg::t_col               r_re;

    rtef_pkg::t_scan_req          scan_req;
    rtef_pkg::t_scan_rsp          scan_rsp;
    logic [rtef_pkg::ADDR_W-1:0]  ram_raddr;
    logic [7:0]                   ram_rdata;
    logic                         ram_we;
    logic                         in_fire;
    logic                         load_out;

    rtef_pkg::t_col shw;
    rtef_pkg::t_col two_hw;
    rtef_pkg::t_col diff_hw;
    rtef_pkg::t_col n_centre;
    rtef_pkg::t_col n_hw;
    rtef_pkg::t_col n_le;
    rtef_pkg::t_col n_re;
    rtef_pkg::t_col clamped;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign ram_we      = in_fire && (r_count < rtef_pkg::CNT_W'(rtef_pkg::ROW_BYTES))
                      && (r_count < rtef_pkg::CNT_W'(rtef_pkg::PIX_WORDS));
    assign load_out    = (r_state == S_CLAMP) && (!o_out_valid || i_out_ready);

    always_comb begin
        scan_req.go       = r_go;
        scan_req.dir_left = r_dir_left;
        scan_req.start    = r_scan_start;
        scan_req.limit    = r_dir_left ? r_left_limit : r_right_limit;
    end

    rtef_ram #(
        .WIDTH (8),
        .DEPTH (rtef_pkg::PIX_WORDS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (rtef_pkg::ADDR_W'(r_count)),
        .i_wdata (i_in_data.pixel_byte),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rtef_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (scan_req),
        .o_rsp   (scan_rsp),
        .o_raddr (ram_raddr),
        .i_rdata (ram_rdata)
    );

    always_comb begin
        shw      = rtef_pkg::t_col'(r_single_hw);
        two_hw   = shw + shw;
        diff_hw  = (r_r - r_l) >>> 1;
        n_centre = rtef_pkg::t_col'(r_scan_start);
        n_hw     = shw;
        n_le     = rtef_pkg::t_col'(r_prev_left);
        n_re     = rtef_pkg::t_col'(r_prev_right);
        case ({r_lf, r_rf})
            2'b01: begin
                n_re     = r_r;
                n_centre = r_r - shw;
                n_le     = r_r - two_hw;
                if (n_le < rtef_pkg::t_col'(0)) begin
                    n_le = rtef_pkg::t_col'(0);
                end
            end
            2'b10: begin
                n_le     = r_l;
                n_centre = r_l + shw;
                n_re     = r_l + two_hw;
                if (n_re > rtef_pkg::t_col'(rtef_pkg::ROW_PIXELS - 1)) begin
                    n_re = rtef_pkg::t_col'(rtef_pkg::ROW_PIXELS - 1);
                end
            end
            2'b11: begin
                n_le     = r_l;
                n_re     = r_r;
                n_centre = (r_r + r_l) >>> 1;
                if (diff_hw < rtef_pkg::t_col'(r_width_low)) begin
                    n_hw = rtef_pkg::t_col'(r_width_low);
                end else if (diff_hw > rtef_pkg::t_col'(r_width_high)) begin
                    n_hw = rtef_pkg::t_col'(r_width_high);
                end else begin
                    n_hw = diff_hw;
                end
            end
            default: begin
                n_centre = rtef_pkg::t_col'(r_scan_start);
            end
        endcase
    end

    always_comb begin
        if (r_centre < rtef_pkg::t_col'(r_centre_low)) begin
            clamped = rtef_pkg::t_col'(r_centre_low);
        end else if (r_centre > rtef_pkg::t_col'(r_centre_high)) begin
            clamped = rtef_pkg::t_col'(r_centre_high);
        end else begin
            clamped = r_centre;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_go          <= 1'b0;
            r_dir_left    <= 1'b0;
            o_out_valid   <= 1'b0;
            r_prev_left   <= '0;
            r_prev_right  <= '0;
            r_scan_start  <= rtef_pkg::RST_SCAN_START;
            r_left_limit  <= rtef_pkg::RST_LEFT_LIMIT;
            r_right_limit <= rtef_pkg::RST_RIGHT_LIMIT;
            r_single_hw   <= rtef_pkg::RST_SINGLE_HW;
            r_width_low   <= rtef_pkg::RST_WIDTH_LOW;
            r_width_high  <= rtef_pkg::RST_WIDTH_HIGH;
            r_centre_low  <= rtef_pkg::RST_CENTRE_LOW;
            r_centre_high <= rtef_pkg::RST_CENTRE_HIGH;
        end else begin
            r_go <= (in_fire && i_in_data.row_end)
                 || ((r_state == S_RIGHT) && scan_rsp.done);
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    rtef_pkg::CFG_SCAN_START:  r_scan_start  <= i_cfg_data;
                    rtef_pkg::CFG_LEFT_LIMIT:  r_left_limit  <= i_cfg_data;
                    rtef_pkg::CFG_RIGHT_LIMIT: r_right_limit <= i_cfg_data;
                    rtef_pkg::CFG_SINGLE_HW:   r_single_hw   <= i_cfg_data[7:0];
                    rtef_pkg::CFG_WIDTH_LOW:   r_width_low   <= i_cfg_data[7:0];
                    rtef_pkg::CFG_WIDTH_HIGH:  r_width_high  <= i_cfg_data[7:0];
                    rtef_pkg::CFG_CENTRE_LOW:  r_centre_low  <= i_cfg_data;
                    rtef_pkg::CFG_CENTRE_HIGH: r_centre_high <= i_cfg_data;
                    default: ;
                endcase
            end
            if (load_out) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_in_data.row_end) begin
                            r_count    <= '0;
                            r_tag      <= i_in_data.row_index;
                            r_dir_left <= 1'b0;
                            r_state    <= S_RIGHT;
                        end else if (r_count < rtef_pkg::CNT_W'(rtef_pkg::ROW_BYTES)) begin
                            r_count <= r_count + rtef_pkg::CNT_W'(1);
                        end
                    end
                end
                S_RIGHT: begin
                    if (scan_rsp.done) begin
                        r_r        <= scan_rsp.edge_col;
                        r_rf       <= scan_rsp.found;
                        r_dir_left <= 1'b1;
                        r_state    <= S_LEFT;
                    end
                end
                S_LEFT: begin
                    if (scan_rsp.done) begin
                        r_l     <= scan_rsp.edge_col;
                        r_lf    <= scan_rsp.found;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_centre <= n_centre;
                    r_hw     <= n_hw;
                    r_le     <= n_le;
                    r_re     <= n_re;
                    r_state  <= S_CLAMP;
                end
                S_CLAMP: begin
                    if (load_out) begin
                        o_out_data.row_tag     <= r_tag;
                        o_out_data.centre_col  <= clamped[8:0];
                        o_out_data.left_edge   <= r_le[8:0];
                        o_out_data.right_edge  <= r_re[8:0];
                        o_out_data.half_width  <= r_hw[7:0];
                        o_out_data.left_found  <= r_lf;
                        o_out_data.right_found <= r_rf;
                        r_prev_left            <= r_le[8:0];
                        r_prev_right           <= r_re[8:0];
                        r_state                <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rtef_pkg::CNT_W'(rtef_pkg::ROW_BYTES))
        else $error("byte count ran past the row length");

    a_row_end_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.row_end) |=> (r_state == S_RIGHT && r_go && !r_dir_left))
        else $error("last byte of a row did not start the right scan");

    a_done_only_scanning: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_rsp.done |-> (r_state == S_RIGHT || r_state == S_LEFT))
        else $error("scan finished outside a scan state");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!o_out_valid || i_out_ready))
        else $error("result loaded over a result not yet taken");

    a_centre_in_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_centre_low <= r_centre_high) |=>
            (o_out_data.centre_col >= $past(r_centre_low)
             && o_out_data.centre_col <= $past(r_centre_high)))
        else $error("reported centre lies outside its clamp");
`endif

endmodule

`default_nettype wire
